// ----- rtl/core/gtp_pkg.sv -----
// Package for the gradient test pattern pixel block.
// Widths, the pipeline word struct, result struct and format codes. No dependencies.
`default_nettype none
package gtp_pkg;
	localparam int MAX_DIMENSION = 4096;
	localparam int COORD_W = 12;
	localparam int DIM_W = 13;
	localparam int DIV_W = 14;
	localparam int REM_W = 22;
	localparam int QUO_W = 8;
	localparam int PITCH_W = 16;
	localparam int OFS_W = 28;
	localparam int WORD_W = 24;
	localparam int CNT_W = 3;
	localparam int DIV_STAGES = 8;
	localparam int IDX_W = 2;
	localparam int CFG_W = 16;

	localparam logic [IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_FORMAT = 2'd2;
	localparam logic [IDX_W-1:0] REG_PITCH = 2'd3;

	typedef enum logic [1:0] {
		FMT_32BPP = 2'd0,
		FMT_24BPP = 2'd1,
		FMT_16BPP = 2'd2,
		FMT_NONE  = 2'd3
	} fmt_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               oof;
		logic [REM_W-1:0]   rem_r;
		logic [REM_W-1:0]   rem_g;
		logic [REM_W-1:0]   rem_b;
		logic [QUO_W-1:0]   q_r;
		logic [QUO_W-1:0]   q_g;
		logic [QUO_W-1:0]   q_b;
	} pipe_t;

	typedef struct packed {
		logic [OFS_W-1:0]  byte_offset;
		logic [WORD_W-1:0] pixel_word;
		logic [CNT_W-1:0]  byte_count;
		logic              out_of_frame;
	} res_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		clamp_dim = (v > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : v;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/core/gtp_if.sv -----
// Valid/ready channel interfaces for coordinate and result words.
// Uses gtp_pkg widths.
`default_nettype none
interface gtp_pix_if;
	logic                        valid;
	logic                        ready;
	logic [gtp_pkg::COORD_W-1:0] pixel_x;
	logic [gtp_pkg::COORD_W-1:0] pixel_y;
	modport source(output valid, output pixel_x, output pixel_y, input ready);
	modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface gtp_res_if;
	logic                       valid;
	logic                       ready;
	logic [gtp_pkg::OFS_W-1:0]  byte_offset;
	logic [gtp_pkg::WORD_W-1:0] pixel_word;
	logic [gtp_pkg::CNT_W-1:0]  byte_count;
	logic                       out_of_frame;
	modport source(output valid, output byte_offset, output pixel_word,
		output byte_count, output out_of_frame, input ready);
	modport sink(input valid, input byte_offset, input pixel_word,
		input byte_count, input out_of_frame, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/gtp_front.sv -----
// Front stage logic: frame check and scaled dividends.
// Uses gtp_pkg.
`default_nettype none
module gtp_front (
	input  wire logic [gtp_pkg::COORD_W-1:0] x,
	input  wire logic [gtp_pkg::COORD_W-1:0] y,
	input  wire logic [gtp_pkg::DIM_W-1:0]   w,
	input  wire logic [gtp_pkg::DIM_W-1:0]   h,
	output gtp_pkg::pipe_t                   nxt
);
	logic [gtp_pkg::REM_W-1:0] xe, ye, se;
	always_comb begin
		xe = gtp_pkg::REM_W'(x);
		ye = gtp_pkg::REM_W'(y);
		se = xe + ye;
		nxt = '0;
		nxt.x = x;
		nxt.y = y;
		nxt.oof = ({1'b0, x} >= w) || ({1'b0, y} >= h);
		nxt.rem_r = (xe << 8) - xe;
		nxt.rem_g = (ye << 8) - ye;
		nxt.rem_b = (se << 8) - se;
	end
endmodule
`default_nettype wire

// ----- rtl/core/gtp_div_step.sv -----
// One restoring division step for the red, green and blue dividers.
// Uses gtp_pkg.
`default_nettype none
module gtp_div_step (
	input  gtp_pkg::pipe_t                 cur,
	input  wire logic [2:0]                k,
	input  wire logic [gtp_pkg::DIV_W-1:0] dw,
	input  wire logic [gtp_pkg::DIV_W-1:0] dh,
	input  wire logic [gtp_pkg::DIV_W-1:0] db,
	output gtp_pkg::pipe_t                 nxt
);
	logic [gtp_pkg::REM_W-1:0] sw, sh, sb;
	always_comb begin
		sw = gtp_pkg::REM_W'(dw) << k;
		sh = gtp_pkg::REM_W'(dh) << k;
		sb = gtp_pkg::REM_W'(db) << k;
		nxt = cur;
		if (cur.rem_r >= sw) begin
			nxt.rem_r = cur.rem_r - sw;
			nxt.q_r[k] = 1'b1;
		end
		if (cur.rem_g >= sh) begin
			nxt.rem_g = cur.rem_g - sh;
			nxt.q_g[k] = 1'b1;
		end
		if (cur.rem_b >= sb) begin
			nxt.rem_b = cur.rem_b - sb;
			nxt.q_b[k] = 1'b1;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/gtp_pack.sv -----
// Output stage logic: color packing, byte count and byte offset.
// Uses gtp_pkg.
`default_nettype none
module gtp_pack (
	input  gtp_pkg::pipe_t                   cur,
	input  gtp_pkg::fmt_t                    fmt,
	input  wire logic [gtp_pkg::PITCH_W-1:0] pitch,
	output gtp_pkg::res_t                    res
);
	logic [gtp_pkg::CNT_W-1:0]  bytes;
	logic [gtp_pkg::WORD_W-1:0] word;
	logic [gtp_pkg::OFS_W-1:0]  ofs;
	always_comb begin
		unique case (fmt)
			gtp_pkg::FMT_32BPP: begin
				bytes = 3'd4;
				word = {cur.q_r, cur.q_g, cur.q_b};
			end
			gtp_pkg::FMT_24BPP: begin
				bytes = 3'd3;
				word = {cur.q_r, cur.q_g, cur.q_b};
			end
			gtp_pkg::FMT_16BPP: begin
				bytes = 3'd2;
				word = {8'd0, cur.q_r[7:3], cur.q_g[7:2], cur.q_b[7:3]};
			end
			default: begin
				bytes = '0;
				word = '0;
			end
		endcase
		ofs = gtp_pkg::OFS_W'(cur.y) * gtp_pkg::OFS_W'(pitch)
			+ gtp_pkg::OFS_W'(cur.x) * gtp_pkg::OFS_W'(bytes);
		res = '0;
		res.out_of_frame = cur.oof;
		if (!cur.oof && bytes != '0) begin
			res.byte_offset = ofs;
			res.pixel_word = word;
			res.byte_count = bytes;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/gradient_test_pattern_pixel.sv -----
// Top level of the gradient test pattern pixel generator.
// Uses gtp_pkg, gtp_if, gtp_front, gtp_div_step, gtp_pack.
//
//  channel | dir | word
//  pix     | in  | pixel_x, pixel_y
//  res     | out | byte_offset, pixel_word, byte_count, out_of_frame
//  cfg     | in  | cfg_we, cfg_index, cfg_data
//
// One word per clock while the result side is ready; pipeline: front stage, eight divider
// stages (one quotient bit each), output register.
// Each stage holds its word while the next is full and stalled; bubbles fill.
// arst_n clears valid bits and loads register reset values.
`default_nettype none
module gradient_test_pattern_pixel (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [gtp_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [gtp_pkg::CFG_W-1:0]   cfg_data,
	gtp_pix_if.sink                          pix,
	gtp_res_if.source                        res
);
	localparam int NS = gtp_pkg::DIV_STAGES + 1;

	logic [gtp_pkg::DIM_W-1:0]   width_q, height_q;
	gtp_pkg::fmt_t               format_q;
	logic [gtp_pkg::PITCH_W-1:0] pitch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= gtp_pkg::DIM_W'(640);
			height_q <= gtp_pkg::DIM_W'(480);
			format_q <= gtp_pkg::FMT_32BPP;
			pitch_q <= gtp_pkg::PITCH_W'(2560);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gtp_pkg::REG_WIDTH:  width_q <= cfg_data[gtp_pkg::DIM_W-1:0];
				gtp_pkg::REG_HEIGHT: height_q <= cfg_data[gtp_pkg::DIM_W-1:0];
				gtp_pkg::REG_FORMAT: format_q <= gtp_pkg::fmt_t'(cfg_data[1:0]);
				default:             pitch_q <= cfg_data;
			endcase
		end
	end

	logic [gtp_pkg::DIM_W-1:0] w, h;
	logic [gtp_pkg::DIV_W-1:0] dw, dh, db;
	assign w = gtp_pkg::clamp_dim(width_q);
	assign h = gtp_pkg::clamp_dim(height_q);
	assign dw = gtp_pkg::DIV_W'(w);
	assign dh = gtp_pkg::DIV_W'(h);
	assign db = dw + dh;

	gtp_pkg::pipe_t pipe_s [NS];
	gtp_pkg::pipe_t nxt [NS];
	gtp_pkg::res_t  out_s;
	gtp_pkg::res_t  out_nxt;
	logic [NS:0]    valid_s;
	logic [NS:0]    rdy;

	gtp_front u_front (
		.x(pix.pixel_x), .y(pix.pixel_y), .w(w), .h(h), .nxt(nxt[0])
	);

	for (genvar i = 1; i < NS; i++) begin : g_div
		gtp_div_step u_step (
			.cur(pipe_s[i-1]), .k(3'(gtp_pkg::DIV_STAGES - i)),
			.dw(dw), .dh(dh), .db(db), .nxt(nxt[i])
		);
	end

	gtp_pack u_pack (
		.cur(pipe_s[NS-1]), .fmt(format_q), .pitch(pitch_q), .res(out_nxt)
	);

	always_comb begin
		rdy[NS] = !valid_s[NS] || res.ready;
		for (int i = NS - 1; i >= 0; i--)
			rdy[i] = !valid_s[i] || rdy[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (rdy[0])
				valid_s[0] <= pix.valid;
			for (int i = 1; i <= NS; i++)
				if (rdy[i])
					valid_s[i] <= valid_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NS; i++)
			if (rdy[i])
				pipe_s[i] <= nxt[i];
		if (rdy[NS])
			out_s <= out_nxt;
	end

	assign pix.ready = rdy[0];
	assign res.valid = valid_s[NS];
	assign res.byte_offset = out_s.byte_offset;
	assign res.pixel_word = out_s.pixel_word;
	assign res.byte_count = out_s.byte_count;
	assign res.out_of_frame = out_s.out_of_frame;
endmodule
`default_nettype wire

// ----- rtl/core/gtp_checker.sv -----
// Port-level checks for gradient_test_pattern_pixel, bound to the top level.
// Uses gtp_pkg widths.
`default_nettype none
module gtp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       res_valid,
	input wire logic                       res_ready,
	input wire logic [gtp_pkg::OFS_W-1:0]  res_offset,
	input wire logic [gtp_pkg::WORD_W-1:0] res_word,
	input wire logic [gtp_pkg::CNT_W-1:0]  res_count,
	input wire logic                       res_oof
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_offset) && $stable(res_word))
		else $error("result word changed under stall");
	a_oof_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_oof |-> res_count == 3'd0 && res_word == '0 && res_offset == '0)
		else $error("out of frame word not zero");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_count == 3'd0 || res_count == 3'd2 || res_count == 3'd3
			|| res_count == 3'd4)
		else $error("bad byte count");
	a_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_count == 3'd0 |-> res_word == '0 && res_offset == '0)
		else $error("no-write word carries data");
	a_16bpp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_count == 3'd2 |-> res_word[23:16] == 8'd0)
		else $error("16bpp word wider than 16 bits");
endmodule

bind gradient_test_pattern_pixel gtp_checker u_gtp_checker (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.res_offset(res.byte_offset), .res_word(res.pixel_word),
	.res_count(res.byte_count), .res_oof(res.out_of_frame)
);
`default_nettype wire

// ----- verif/gtp_checker.sv -----
// Checker for the gradient test pattern pixel block: watches the coordinate and
// result channels, predicts each result word and compares. Depends on gtp_pkg, gtp_if.
`default_nettype none
module gtp_scoreboard (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [gtp_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [gtp_pkg::CFG_W-1:0] cfg_data,
	gtp_pix_if                             pix,
	gtp_res_if                             res,
	output int                             errors,
	output int                             pending
);
	import gtp_pkg::*;

	logic [DIM_W-1:0]   width_reg;
	logic [DIM_W-1:0]   height_reg;
	fmt_t               fmt_reg;
	logic [PITCH_W-1:0] pitch_reg;
	res_t               expected_q[$];

	function automatic res_t gradient_pixel(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y);
		res_t o;
		longint w, h, r, g, b, nb;
		o = '0;
		w = (width_reg > MAX_DIMENSION) ? MAX_DIMENSION : width_reg;
		h = (height_reg > MAX_DIMENSION) ? MAX_DIMENSION : height_reg;
		if (x >= w || y >= h) begin
			o.out_of_frame = 1'b1;
			return o;
		end
		r = (longint'(x) * 255) / w;
		g = (longint'(y) * 255) / h;
		b = ((longint'(x) + longint'(y)) * 255) / (w + h);
		nb = 0;
		case (fmt_reg)
			FMT_32BPP: begin
				nb = 4;
				o.pixel_word = WORD_W'((r << 16) | (g << 8) | b);
			end
			FMT_24BPP: begin
				nb = 3;
				o.pixel_word = WORD_W'((r << 16) | (g << 8) | b);
			end
			FMT_16BPP: begin
				nb = 2;
				o.pixel_word = WORD_W'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
			end
			default: o.pixel_word = '0;
		endcase
		if (nb != 0) begin
			o.byte_offset = OFS_W'(longint'(y) * pitch_reg + longint'(x) * nb);
			o.byte_count = CNT_W'(nb);
		end
		return o;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			width_reg <= 13'd640;
			height_reg <= 13'd480;
			fmt_reg <= FMT_32BPP;
			pitch_reg <= 16'd2560;
			errors <= 0;
			expected_q.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					e = expected_q.pop_front();
					if (res.byte_offset !== e.byte_offset)
						report("byte_offset", res.byte_offset, e.byte_offset);
					if (res.pixel_word !== e.pixel_word)
						report("pixel_word", res.pixel_word, e.pixel_word);
					if (res.byte_count !== e.byte_count)
						report("byte_count", res.byte_count, e.byte_count);
					if (res.out_of_frame !== e.out_of_frame)
						report("out_of_frame", res.out_of_frame, e.out_of_frame);
				end
			end
			if (pix.valid && pix.ready)
				expected_q.push_back(gradient_pixel(pix.pixel_x, pix.pixel_y));
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH:  width_reg <= cfg_data[DIM_W-1:0];
					REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
					REG_FORMAT: fmt_reg <= fmt_t'(cfg_data[1:0]);
					REG_PITCH:  pitch_reg <= cfg_data;
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench top for gradient_test_pattern_pixel: drives coordinates and register
// settings, random stalls on both sides; gtp_scoreboard does the prediction.
`default_nettype none
module tb;
	import gtp_pkg::*;

	localparam int LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	int                 errors, pending, cycles = 0, sent = 0, phases = 0;

	gtp_pix_if pix();
	gtp_res_if res();

	gradient_test_pattern_pixel u_dut (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.pix(pix.sink), .res(res.source));
	gtp_scoreboard u_chk (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .pix(pix),
		.res(res), .errors, .pending);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		res.ready = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side stalls
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
			n = $urandom_range(0, 4);
			if ($urandom_range(0, 9) < 3) n = 0;
			if (n != 0) begin
				@(negedge clk);
				res.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		int n;
		n = $urandom_range(0, 4);
		if ($urandom_range(0, 9) < 3) n = 0;
		if (n != 0) begin
			pix.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= x;
		pix.pixel_y <= y;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input int unsigned w, input int unsigned h,
		input fmt_t f, input int unsigned p);
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_FORMAT, f);
		write_reg(REG_PITCH, p);
		phases++;
	endtask

	task automatic random_phase(input int count, input int unsigned w, input int unsigned h);
		logic [COORD_W-1:0] x, y;
		repeat (count) begin
			if ($urandom_range(0, 9) < 8 && w > 0 && h > 0) begin
				x = COORD_W'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
				y = COORD_W'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
			end else begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
			end
			send_pixel(x, y);
		end
	endtask

	initial begin
		int unsigned w, h;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// reset settings: corners, edges, out of frame
		send_pixel(0, 0);
		send_pixel(639, 479);
		send_pixel(640, 0);
		send_pixel(0, 480);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'hAAA, 12'h555);
		configure(4096, 4096, FMT_24BPP, 65535);
		send_pixel(4095, 4095);
		send_pixel(12'h555, 12'hAAA);
		send_pixel(0, 4095);
		configure(8191, 8191, FMT_16BPP, 1);
		send_pixel(4095, 4095);
		send_pixel(2048, 1);
		configure(0, 10, FMT_32BPP, 100);
		send_pixel(0, 0);
		configure(1, 1, FMT_NONE, 7);
		send_pixel(0, 0);
		send_pixel(1, 0);
		configure(1, 1, FMT_32BPP, 65535);
		send_pixel(0, 0);
		configure(13, 4096, FMT_16BPP, 3);
		send_pixel(12, 4095);
		send_pixel(13, 4095);
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: w = $urandom_range(1, 64);
				1: w = $urandom_range(1, 4096);
				2: w = $urandom_range(4090, 8191);
				default: w = $urandom_range(1, 8191);
			endcase
			h = (ph % 3 == 0) ? $urandom_range(1, 32) : $urandom_range(1, 8191);
			configure(w, h, fmt_t'($urandom_range(0, 3)), $urandom_range(1, 65535));
			random_phase(52, w, h);
		end
		settle();
		$display("Sent %0d coordinate words over %0d register settings", sent, phases);
		$display("Formats 32/24/16bpp and unsupported, in and out of frame, clamped sizes");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
